### rtl/h264_rtp_fua_packetizer_assert.svh
// Assertion helpers shared by the queue and back-end modules.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef H264_RTP_FUA_PACKETIZER_ASSERT_SVH
`define H264_RTP_FUA_PACKETIZER_ASSERT_SVH

// Same-cycle implication.
`define H264FU_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define H264FU_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/h264fu_pkg.sv
`timescale 1ns / 1ps
package h264fu_pkg;

  // Field and register widths
  localparam int LEN_W  = 20;  // NAL length width
  localparam int PLEN_W = 11;  // payload length / max_payload width
  localparam int RLEN_W = 16;  // RTP length in framing prefix
  localparam int SEQ_W  = 16;
  localparam int TS_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SSRC      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAXP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TS_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL   = 3'd4;

  // Reset values
  localparam logic [31:0]       SSRC_RST    = 32'h3918_0001;
  localparam logic [6:0]        PT_RST      = 7'd96;
  localparam logic [PLEN_W-1:0] MAXP_RST    = 11'd1200;
  localparam logic [TS_W-1:0]   TS_STEP_RST = 32'd9000;
  localparam logic [7:0]        CHANNEL_RST = 8'd0;
  localparam logic [SEQ_W-1:0]  SEQ_RST     = 16'd1;
  localparam logic [TS_W-1:0]   TS_RST      = 32'd1;

  // Protocol constants
  localparam logic [PLEN_W-1:0] MAXP_MIN    = 11'd3;
  localparam logic [PLEN_W-1:0] FU_OVERHEAD = 11'd2;
  localparam logic [RLEN_W-1:0] RTP_HDR_LEN = 16'd12;
  localparam logic [7:0]  FRAME_MAGIC = 8'h24;  // '$'
  localparam logic [7:0]  RTP_V2      = 8'h80;
  localparam logic [4:0]  FU_A_TYPE   = 5'd28;

  // Command queue depth
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Byte positions inside one expanded command
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_DOLLAR  = 5'd0;
  localparam logic [POS_W-1:0] POS_CHAN    = 5'd1;
  localparam logic [POS_W-1:0] POS_LEN_HI  = 5'd2;
  localparam logic [POS_W-1:0] POS_LEN_LO  = 5'd3;
  localparam logic [POS_W-1:0] POS_VER     = 5'd4;
  localparam logic [POS_W-1:0] POS_PT      = 5'd5;
  localparam logic [POS_W-1:0] POS_SEQ_HI  = 5'd6;
  localparam logic [POS_W-1:0] POS_SEQ_LO  = 5'd7;
  localparam logic [POS_W-1:0] POS_TS_3    = 5'd8;
  localparam logic [POS_W-1:0] POS_TS_2    = 5'd9;
  localparam logic [POS_W-1:0] POS_TS_1    = 5'd10;
  localparam logic [POS_W-1:0] POS_TS_0    = 5'd11;
  localparam logic [POS_W-1:0] POS_SSRC_3  = 5'd12;
  localparam logic [POS_W-1:0] POS_SSRC_2  = 5'd13;
  localparam logic [POS_W-1:0] POS_SSRC_1  = 5'd14;
  localparam logic [POS_W-1:0] POS_SSRC_0  = 5'd15;
  localparam logic [POS_W-1:0] POS_FU_IND  = 5'd16;
  localparam logic [POS_W-1:0] POS_FU_HDR  = 5'd17;
  localparam logic [POS_W-1:0] POS_DATA    = 5'd18;

  // Configuration seen by front and back
  typedef struct packed {
    logic [31:0]       ssrc;
    logic [6:0]        pt;
    logic [PLEN_W-1:0] max_payload;
    logic [TS_W-1:0]   ts_step;
    logic [7:0]        channel;
  } cfg_t;

  // One classified word headed for the back end
  typedef struct packed {
    logic [7:0]        data;
    logic              pend;    // data byte closes the frame
    logic              hdr;     // frame prefix + RTP header precede data
    logic              fu;      // FU indicator/header precede data
    logic              mark;
    logic [RLEN_W-1:0] rlen;
    logic [SEQ_W-1:0]  seq;
    logic [TS_W-1:0]   ts;
    logic [7:0]        fu_ind;
    logic [7:0]        fu_hdr;
  } cmd_t;

endpackage

### rtl/h264_rtp_fua_packetizer.sv
`timescale 1ns / 1ps
// H.264 NAL to interleaved RTP-over-TCP packetizer with FU-A fragmentation.
// Input channel: one NAL byte per word (in_valid_i / in_stall_o); nal_start_i
// marks the header byte and qualifies nal_length_i and ends_unit_i.
// Output channel: one framed byte per word (out_valid_o / out_stall_i);
// packet_end_o flags the last byte of a frame, last_o the last word caused
// by one input word. Configuration is written through cfg_we_i/cfg_idx_i/
// cfg_data_i; the user must write it only while the block is idle, as the
// block does not enforce it. Unknown indexes are ignored. The first output
// word of an item passes the command queue and the output register. A byte
// that opens a packet is preceded by the frame prefix, RTP header and, for
// FU-A, FU bytes; the output register emits one byte per cycle unless
// out_stall_i holds it. The two-entry command queue keeps the input flowing
// while headers drain; stored FU-A header and stray bytes give no output.
// Reset: config returns to its defaults, sequence and timestamp to 1, the
// queue and output register empty. A stall on the output holds the word
// and, once the queue fills, raises in_stall_o.
module h264_rtp_fua_packetizer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [h264fu_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [h264fu_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 nal_start_i,
  input  logic [h264fu_pkg::LEN_W-1:0]         nal_length_i,
  input  logic                                 ends_unit_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [7:0]                           out_byte_o,
  output logic                                 packet_end_o,
  output logic                                 last_o
);
  import h264fu_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, head_cmd;
  logic push, pop, q_empty, q_full;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ssrc        <= SSRC_RST;
      cfg_q.pt          <= PT_RST;
      cfg_q.max_payload <= MAXP_RST;
      cfg_q.ts_step     <= TS_STEP_RST;
      cfg_q.channel     <= CHANNEL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SSRC:    cfg_q.ssrc        <= cfg_data_i;
        REG_PT:      cfg_q.pt          <= cfg_data_i[6:0];
        REG_MAXP:    cfg_q.max_payload <= cfg_data_i[PLEN_W-1:0];
        REG_TS_STEP: cfg_q.ts_step     <= cfg_data_i;
        REG_CHANNEL: cfg_q.channel     <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  h264fu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .nal_start_i  (nal_start_i),
    .nal_length_i (nal_length_i),
    .ends_unit_i  (ends_unit_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  h264fu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (q_empty),
    .full_o      (q_full)
  );

  h264fu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head_cmd),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .last_o       (last_o)
  );

endmodule

### rtl/h264fu_front.sv
`timescale 1ns / 1ps
module h264fu_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  h264fu_pkg::cfg_t          cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                data_byte_i,
  input  logic                      nal_start_i,
  input  logic [h264fu_pkg::LEN_W-1:0] nal_length_i,
  input  logic                      ends_unit_i,
  input  logic                      q_full_i,
  output logic                      push_o,
  output h264fu_pkg::cmd_t          cmd_o
);
  import h264fu_pkg::*;

  logic [LEN_W-1:0]  rest_q, rest_d;        // NAL bytes not yet taken
  logic [PLEN_W-1:0] chunk_q, chunk_d;      // bytes left in open packet
  logic [7:0]        saved_q, saved_d;
  logic              frag_q, frag_d;
  logic              first_q, first_d;      // next fragment is the first
  logic              mark_q, mark_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [TS_W-1:0]   ts_q, ts_d;

  logic              accept;
  logic [PLEN_W-1:0] maxp, frag_len;
  logic [LEN_W-1:0]  len_eff;
  logic              frag_new;
  logic [LEN_W-1:0]  e_rest;
  logic [PLEN_W-1:0] e_chunk;
  logic [7:0]        e_saved;
  logic              e_frag, e_first, e_mark;
  logic              produce, need_hdr, fin;
  logic [PLEN_W-1:0] chunk_sel, plen, c_eff;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // Effective state after a possible NAL start
  always_comb begin
    maxp     = (cfg_i.max_payload < MAXP_MIN) ? MAXP_MIN : cfg_i.max_payload;
    frag_len = maxp - FU_OVERHEAD;
    len_eff  = (nal_length_i == '0) ? LEN_W'(1) : nal_length_i;
    frag_new = len_eff > LEN_W'(maxp);
    if (nal_start_i) begin
      e_rest  = len_eff;
      e_chunk = '0;
      e_saved = data_byte_i;
      e_frag  = frag_new;
      e_first = 1'b1;
      e_mark  = ends_unit_i;
      produce = !frag_new;
    end else begin
      e_rest  = rest_q;
      e_chunk = chunk_q;
      e_saved = saved_q;
      e_frag  = frag_q;
      e_first = first_q;
      e_mark  = mark_q;
      produce = (rest_q != '0);
    end
  end

  // Packet sizing for the word that goes out
  always_comb begin
    need_hdr = (e_chunk == '0);
    fin      = (e_rest <= LEN_W'(frag_len));
    if (e_frag && !fin) chunk_sel = frag_len;
    else                chunk_sel = e_rest[PLEN_W-1:0];
    plen  = e_frag ? (chunk_sel + FU_OVERHEAD) : chunk_sel;
    c_eff = need_hdr ? chunk_sel : e_chunk;
  end

  // Next state
  always_comb begin
    rest_d  = rest_q;
    chunk_d = chunk_q;
    saved_d = saved_q;
    frag_d  = frag_q;
    first_d = first_q;
    mark_d  = mark_q;
    seq_d   = seq_q;
    ts_d    = ts_q;
    if (accept) begin
      saved_d = e_saved;
      frag_d  = e_frag;
      mark_d  = e_mark;
      first_d = e_first;
      chunk_d = e_chunk;
      if (nal_start_i || rest_q != '0) begin
        // a fragmented header byte is only stored: it still uses one NAL byte
        rest_d = e_rest - LEN_W'(1);
      end
      if (produce) begin
        chunk_d = c_eff - PLEN_W'(1);
        if (need_hdr) begin
          seq_d = seq_q + SEQ_W'(1);
          if (e_frag) first_d = 1'b0;
        end
        if (e_rest == LEN_W'(1) && e_mark) ts_d = ts_q + cfg_i.ts_step;
      end
    end
  end

  // Word for the back end
  always_comb begin
    push_o        = accept && produce;
    cmd_o.data    = data_byte_i;
    cmd_o.pend    = (c_eff == PLEN_W'(1));
    cmd_o.hdr     = need_hdr;
    cmd_o.fu      = need_hdr && e_frag;
    cmd_o.mark    = e_frag ? (fin && e_mark) : e_mark;
    cmd_o.rlen    = RTP_HDR_LEN + RLEN_W'(plen);
    cmd_o.seq     = seq_q;
    cmd_o.ts      = ts_q;
    cmd_o.fu_ind  = {e_saved[7:5], FU_A_TYPE};
    cmd_o.fu_hdr  = {e_first, fin, 1'b0, e_saved[4:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q  <= '0;
      chunk_q <= '0;
      saved_q <= '0;
      frag_q  <= 1'b0;
      first_q <= 1'b0;
      mark_q  <= 1'b0;
      seq_q   <= SEQ_RST;
      ts_q    <= TS_RST;
    end else begin
      rest_q  <= rest_d;
      chunk_q <= chunk_d;
      saved_q <= saved_d;
      frag_q  <= frag_d;
      first_q <= first_d;
      mark_q  <= mark_d;
      seq_q   <= seq_d;
      ts_q    <= ts_d;
    end
  end

endmodule

### rtl/h264fu_queue.sv
`timescale 1ns / 1ps
module h264fu_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  h264fu_pkg::cmd_t push_data_i,
  input  logic             pop_i,
  output h264fu_pkg::cmd_t head_o,
  output logic             empty_o,
  output logic             full_o
);
  import h264fu_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == QCNT_W'(QDEPTH));
  assign head_o  = mem_q[rd_ptr_q];

  // Pointer and fill-count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i)      count_d = count_q + QCNT_W'(1);
    else if (pop_i && !push_i) count_d = count_q - QCNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

`include "h264_rtp_fua_packetizer_assert.svh"

  `H264FU_ASSERT_IMP(a_cnt_range, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue count overrun")
  `H264FU_ASSERT_IMP(a_no_push_full, full_o && !pop_i, !push_i, "push into full queue")
  `H264FU_ASSERT_NXT(a_cnt_grow, push_i && !pop_i, count_q == $past(count_q) + QCNT_W'(1),
                     "count did not follow push")

endmodule

### rtl/h264fu_back.sv
`timescale 1ns / 1ps
module h264fu_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  h264fu_pkg::cfg_t cfg_i,
  input  h264fu_pkg::cmd_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             packet_end_o,
  output logic             last_o
);
  import h264fu_pkg::*;

  logic             started_q, started_d;   // head word partly expanded
  logic [POS_W-1:0] pos_q, pos_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             packet_end_q, packet_end_d;
  logic             last_q, last_d;

  logic             out_ready, load;
  logic [POS_W-1:0] cur_pos;
  logic [7:0]       byte_sel;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign load      = out_ready && !empty_i;
  assign cur_pos   = started_q ? pos_q : (head_i.hdr ? POS_DOLLAR : POS_DATA);
  assign pop_o     = load && (cur_pos == POS_DATA);

  // Byte at the current position
  always_comb begin
    case (cur_pos)
      POS_DOLLAR: byte_sel = FRAME_MAGIC;
      POS_CHAN:   byte_sel = cfg_i.channel;
      POS_LEN_HI: byte_sel = head_i.rlen[15:8];
      POS_LEN_LO: byte_sel = head_i.rlen[7:0];
      POS_VER:    byte_sel = RTP_V2;
      POS_PT:     byte_sel = {head_i.mark, cfg_i.pt};
      POS_SEQ_HI: byte_sel = head_i.seq[15:8];
      POS_SEQ_LO: byte_sel = head_i.seq[7:0];
      POS_TS_3:   byte_sel = head_i.ts[31:24];
      POS_TS_2:   byte_sel = head_i.ts[23:16];
      POS_TS_1:   byte_sel = head_i.ts[15:8];
      POS_TS_0:   byte_sel = head_i.ts[7:0];
      POS_SSRC_3: byte_sel = cfg_i.ssrc[31:24];
      POS_SSRC_2: byte_sel = cfg_i.ssrc[23:16];
      POS_SSRC_1: byte_sel = cfg_i.ssrc[15:8];
      POS_SSRC_0: byte_sel = cfg_i.ssrc[7:0];
      POS_FU_IND: byte_sel = head_i.fu_ind;
      POS_FU_HDR: byte_sel = head_i.fu_hdr;
      default:    byte_sel = head_i.data;
    endcase
  end

  // Sequencer and output register
  always_comb begin
    started_d    = started_q;
    pos_d        = pos_q;
    out_valid_d  = out_valid_q;
    out_byte_d   = out_byte_q;
    packet_end_d = packet_end_q;
    last_d       = last_q;
    if (out_ready) begin
      out_valid_d = load;
    end
    if (load) begin
      out_byte_d   = byte_sel;
      packet_end_d = (cur_pos == POS_DATA) && head_i.pend;
      last_d       = (cur_pos == POS_DATA);
      if (cur_pos == POS_DATA) begin
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        if (cur_pos == POS_SSRC_0) pos_d = head_i.fu ? POS_FU_IND : POS_DATA;
        else                       pos_d = cur_pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      pos_q       <= POS_DOLLAR;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q   <= out_byte_d;
    packet_end_q <= packet_end_d;
    last_q       <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign packet_end_o = packet_end_q;
  assign last_o       = last_q;

`include "h264_rtp_fua_packetizer_assert.svh"

  `H264FU_ASSERT_IMP(a_pend_last, out_valid_q && packet_end_q, last_q,
                     "frame end not on last word of item")
  `H264FU_ASSERT_IMP(a_started_head, started_q, !empty_i && pos_q != POS_DOLLAR,
                     "expansion without head word")
  `H264FU_ASSERT_IMP(a_fu_pos, started_q && (pos_q == POS_FU_IND || pos_q == POS_FU_HDR),
                     head_i.fu, "FU bytes on unfragmented packet")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import h264fu_pkg::*;

  localparam int WATCHDOG      = 2000;  // cycles with no word moved on either side
  localparam int SETTLE_CYCLES = 24;    // pipeline drain allowance before config writes
  localparam int PHASE_WORDS   = 124;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_DIR       = 28;

  typedef enum logic [1:0] {ROW_WORD, ROW_QUIET, ROW_REG} row_kind_e;

  // One directed step: a NAL byte, a byte known to give no output, or a register write
  typedef struct packed {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          value;
    logic                 start;
    logic [LEN_W-1:0]     len;
    logic                 ends;
  } row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       pend;
    logic       last;
  } frame_byte_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = '0;
  logic                  nal_start = 1'b0;
  logic [LEN_W-1:0]      nal_length = '0;
  logic                  ends_unit = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_byte;
  logic                  packet_end;
  logic                  last_word;

  h264_rtp_fua_packetizer uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .data_byte_i  (data_byte),
    .nal_start_i  (nal_start),
    .nal_length_i (nal_length),
    .ends_unit_i  (ends_unit),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .packet_end_o (packet_end),
    .last_o       (last_word)
  );

  always #6 clk = ~clk;

  // Packetizer shadow: config copy and stream state
  logic [31:0]       sh_ssrc;
  logic [6:0]        sh_pt;
  logic [PLEN_W-1:0] sh_maxp;
  logic [TS_W-1:0]   sh_ts_step;
  logic [7:0]        sh_chan;
  logic [SEQ_W-1:0]  sh_seq;
  logic [TS_W-1:0]   sh_ts;
  logic [LEN_W-1:0]  sh_offset;
  logic [LEN_W-1:0]  sh_total;
  logic [PLEN_W-1:0] sh_chunk_left;
  logic [7:0]        sh_nal_hdr;
  logic              sh_frag;
  logic              sh_marker;

  frame_byte_t frame_q[$];  // framed bytes still owed by the block
  int          mismatches = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          quiet_cycles = 0;
  row_t        dir_rows [NUM_DIR];

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic pend);
    frame_q.push_back('{data: b, pend: pend, last: 1'b0});
  endtask

  // '$' prefix plus 12-byte RTP header; bumps the sequence number
  task automatic push_rtp_header(input int plen, input logic mark);
    logic [RLEN_W-1:0] rlen;
    rlen = RTP_HDR_LEN + RLEN_W'(plen);
    push_byte(FRAME_MAGIC, 1'b0);
    push_byte(sh_chan, 1'b0);
    push_byte(rlen[15:8], 1'b0);
    push_byte(rlen[7:0], 1'b0);
    push_byte(RTP_V2, 1'b0);
    push_byte({mark, sh_pt}, 1'b0);
    push_byte(sh_seq[15:8], 1'b0);
    push_byte(sh_seq[7:0], 1'b0);
    push_byte(sh_ts[31:24], 1'b0);
    push_byte(sh_ts[23:16], 1'b0);
    push_byte(sh_ts[15:8], 1'b0);
    push_byte(sh_ts[7:0], 1'b0);
    push_byte(sh_ssrc[31:24], 1'b0);
    push_byte(sh_ssrc[23:16], 1'b0);
    push_byte(sh_ssrc[15:8], 1'b0);
    push_byte(sh_ssrc[7:0], 1'b0);
    sh_seq = sh_seq + 1'b1;
  endtask

  // Expected framed bytes for one accepted NAL byte; n is how many it causes
  task automatic packetize_byte(input logic [7:0] b, input logic st,
                                input logic [LEN_W-1:0] len, input logic ends,
                                output int n);
    int   maxp;
    int   rest;
    int   chunk;
    int   base;
    logic fin;
    n = 0;
    base = frame_q.size();
    maxp = (sh_maxp < MAXP_MIN) ? int'(MAXP_MIN) : int'(sh_maxp);
    if (st) begin
      sh_total = (len == '0) ? LEN_W'(1) : len;
      sh_offset = '0;
      sh_chunk_left = '0;
      sh_marker = ends;
      sh_nal_hdr = b;
      sh_frag = (int'(sh_total) > maxp);
      // fragmented NAL: header byte only feeds the FU bytes
      if (sh_frag) begin
        sh_offset = LEN_W'(1);
        return;
      end
    end else if (sh_offset >= sh_total) begin
      return;  // stray byte
    end

    if (sh_chunk_left == '0) begin
      rest = int'(sh_total) - int'(sh_offset);
      if (sh_frag) begin
        chunk = (rest > maxp - int'(FU_OVERHEAD)) ? maxp - int'(FU_OVERHEAD) : rest;
        fin = (int'(sh_offset) + chunk >= int'(sh_total));
        push_rtp_header(chunk + int'(FU_OVERHEAD), fin && sh_marker);
        push_byte({sh_nal_hdr[7:5], FU_A_TYPE}, 1'b0);
        push_byte({(sh_offset == LEN_W'(1)), fin, 1'b0, sh_nal_hdr[4:0]}, 1'b0);
        sh_chunk_left = PLEN_W'(chunk);
      end else begin
        push_rtp_header(rest, sh_marker);
        sh_chunk_left = PLEN_W'(rest);
      end
    end

    sh_chunk_left = sh_chunk_left - 1'b1;
    sh_offset = sh_offset + 1'b1;
    push_byte(b, sh_chunk_left == '0);
    if (sh_offset >= sh_total && sh_marker)
      sh_ts = sh_ts + sh_ts_step;
    n = frame_q.size() - base;
    frame_q[frame_q.size() - 1].last = 1'b1;
  endtask

  // Offer one word, honoring random sender gaps; predict once accepted
  task automatic send_word(input logic [7:0] b, input logic st,
                           input logic [LEN_W-1:0] len, input logic ends,
                           output int n);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    nal_start  <= st;
    nal_length <= len;
    ends_unit  <= ends;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    packetize_byte(b, st, len, ends, n);
  endtask

  // Hold the input off until every owed byte is out, then wait extra cycles
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (frame_q.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      REG_SSRC:    sh_ssrc = value;
      REG_PT:      sh_pt = value[6:0];
      REG_MAXP:    sh_maxp = value[PLEN_W-1:0];
      REG_TS_STEP: sh_ts_step = value;
      REG_CHANNEL: sh_chan = value[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random receiver stalls
  always @(posedge clk)
    out_stall <= ($urandom_range(99) < recv_idle);

  // Output checker and watchdog
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          flag_mismatch("unexpected word", 0, out_byte);
        end else begin
          want = frame_q.pop_front();
          if (out_byte !== want.data)
            flag_mismatch("out_byte", want.data, out_byte);
          if (packet_end !== want.pend)
            flag_mismatch("packet_end", want.pend, packet_end);
          if (last_word !== want.last)
            flag_mismatch("last", want.last, last_word);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG) begin
        $display("FAIL h264_rtp_fua_packetizer");
        $finish;
      end
    end
  end

  initial begin
    row_t              row;
    int                n;
    int                pick;
    int                nal_len;
    int                sent;
    int                done;
    logic              st;
    logic [31:0]       cfg_word;
    logic [PLEN_W-1:0] maxp_pick;

    sh_ssrc       = SSRC_RST;
    sh_pt         = PT_RST;
    sh_maxp       = MAXP_RST;
    sh_ts_step    = TS_STEP_RST;
    sh_chan       = CHANNEL_RST;
    sh_seq        = SEQ_RST;
    sh_ts         = TS_RST;
    sh_offset     = '0;
    sh_total      = '0;
    sh_chunk_left = '0;
    sh_nal_hdr    = '0;
    sh_frag       = 1'b0;
    sh_marker     = 1'b0;

    dir_rows = '{
      // defaults after reset: stray bytes, tiny NALs, zero length
      '{ROW_QUIET, '0, 32'h5A, 1'b0, 20'd0, 1'b0},
      '{ROW_WORD,  '0, 32'h00, 1'b1, 20'd1, 1'b0},
      '{ROW_QUIET, '0, 32'hFF, 1'b0, 20'hFFFFF, 1'b1},
      '{ROW_WORD,  '0, 32'hFF, 1'b1, 20'd0, 1'b1},
      '{ROW_WORD,  '0, 32'h65, 1'b1, 20'd3, 1'b1},
      '{ROW_WORD,  '0, 32'hAA, 1'b0, 20'd0, 1'b0},
      '{ROW_WORD,  '0, 32'h55, 1'b0, 20'd0, 1'b0},
      // max_payload below the floor, all other registers at their top
      '{ROW_REG, REG_MAXP,    32'h0, 1'b0, 20'd0, 1'b0},
      '{ROW_REG, REG_SSRC,    32'hFFFF_FFFF, 1'b0, 20'd0, 1'b0},
      '{ROW_REG, REG_PT,      32'hFFFF_FFFF, 1'b0, 20'd0, 1'b0},
      '{ROW_REG, REG_TS_STEP, 32'hFFFF_FFFF, 1'b0, 20'd0, 1'b0},
      '{ROW_REG, REG_CHANNEL, 32'hFFFF_FFFF, 1'b0, 20'd0, 1'b0},
      // FU-A: header byte is only stored
      '{ROW_QUIET, '0, 32'h7C, 1'b1, 20'd5, 1'b1},
      '{ROW_WORD,  '0, 32'h11, 1'b0, 20'd0, 1'b0},
      '{ROW_WORD,  '0, 32'h22, 1'b0, 20'd0, 1'b1},
      '{ROW_WORD,  '0, 32'h33, 1'b0, 20'd0, 1'b0},
      '{ROW_WORD,  '0, 32'h44, 1'b0, 20'd0, 1'b0},
      // longest length, abandoned by an early start
      '{ROW_QUIET, '0, 32'hE5, 1'b1, 20'hFFFFF, 1'b1},
      '{ROW_WORD,  '0, 32'h01, 1'b0, 20'd0, 1'b0},
      '{ROW_WORD,  '0, 32'h41, 1'b1, 20'd2, 1'b0},
      '{ROW_WORD,  '0, 32'h02, 1'b0, 20'd0, 1'b0},
      // max_payload past the nominal top, everything else at zero
      '{ROW_REG, REG_MAXP,    32'h7FF, 1'b0, 20'd0, 1'b0},
      '{ROW_REG, REG_SSRC,    32'h0, 1'b0, 20'd0, 1'b0},
      '{ROW_REG, REG_PT,      32'h0, 1'b0, 20'd0, 1'b0},
      '{ROW_REG, REG_TS_STEP, 32'h0, 1'b0, 20'd0, 1'b0},
      '{ROW_REG, REG_CHANNEL, 32'h0, 1'b0, 20'd0, 1'b0},
      '{ROW_WORD,  '0, 32'h09, 1'b1, 20'd2, 1'b1},
      '{ROW_WORD,  '0, 32'h80, 1'b0, 20'd0, 1'b0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    send_idle = 16;
    recv_idle = 68;
    for (int i = 0; i < NUM_DIR; i++) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        settle(SETTLE_CYCLES);
        write_reg(row.idx, row.value);
      end else begin
        send_word(row.value[7:0], row.start, row.len, row.ends, n);
        if (row.kind == ROW_QUIET && n != 0)
          flag_mismatch("output count of silent byte", 0, n);
      end
    end

    // Unmapped register indexes must be ignored
    settle(SETTLE_CYCLES);
    for (int k = int'(REG_CHANNEL) + 1; k < (1 << CFG_IDX_W); k++)
      write_reg(CFG_IDX_W'(k), $urandom);

    // Random phases with different idling mixes
    for (int ph = 0; ph < 3; ph++) begin
      settle(SETTLE_CYCLES);
      case (ph)
        0: begin
          send_idle = 16;
          recv_idle = 68;
          maxp_pick = PLEN_W'($urandom_range(3, 12));
        end
        1: begin
          send_idle = 68;
          recv_idle = 16;
          maxp_pick = PLEN_W'($urandom_range(0, 2));
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
          maxp_pick = PLEN_W'($urandom_range(13, 40));
        end
      endcase
      write_reg(REG_SSRC, $urandom);
      write_reg(REG_PT, $urandom);
      cfg_word = $urandom;
      cfg_word[PLEN_W-1:0] = maxp_pick;
      write_reg(REG_MAXP, cfg_word);
      write_reg(REG_TS_STEP, $urandom);
      write_reg(REG_CHANNEL, $urandom);

      done = 0;
      while (done < PHASE_WORDS) begin
        pick = $urandom_range(99);
        // now and then let the output run dry
        if (pick < 3)
          settle(0);
        if (pick < 90) begin
          if (pick < 80) begin
            nal_len = $urandom_range(0, 40);
            sent = (nal_len == 0) ? 1 : nal_len;
          end else begin
            // broken NAL, cut short by the next start
            nal_len = $urandom_range(2, 60);
            sent = $urandom_range(1, nal_len - 1);
          end
          for (int j = 0; j < sent; j++) begin
            if (j == 0) begin
              send_word(8'($urandom), 1'b1, LEN_W'(nal_len), 1'($urandom), n);
              done++;
            end else begin
              send_word(8'($urandom), 1'b0, LEN_W'($urandom), 1'($urandom), n);
              if (n != 0)
                done++;
            end
          end
        end else begin
          // noise: random starts with any length, stray bytes
          repeat ($urandom_range(1, 4)) begin
            st = 1'($urandom);
            send_word(8'($urandom), st, LEN_W'($urandom), 1'($urandom), n);
            if (n != 0 || st)
              done++;
          end
        end
      end
    end

    settle(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("PASS h264_rtp_fua_packetizer");
    end else begin
      $display("FAIL h264_rtp_fua_packetizer");
    end
    $finish;
  end

endmodule
